>>> sv/ppt_pkg.sv
// Package for the promotable priority table.
// Holds operation codes, response status codes and the controller state type.
// No dependencies.
`default_nettype none

package ppt_pkg;

   localparam int FUNC_WIDTH = 3;
   localparam int STAT_WIDTH = 2;

   localparam logic [FUNC_WIDTH-1:0] FN_ADD      = 3'd0;
   localparam logic [FUNC_WIDTH-1:0] FN_PROMOTE  = 3'd1;
   localparam logic [FUNC_WIDTH-1:0] FN_GET_MAX  = 3'd2;
   localparam logic [FUNC_WIDTH-1:0] FN_POP_MAX  = 3'd3;
   localparam logic [FUNC_WIDTH-1:0] FN_IS_VALID = 3'd4;
   localparam logic [FUNC_WIDTH-1:0] FN_GET      = 3'd5;

   localparam logic [STAT_WIDTH-1:0] STAT_OK    = 2'd0;
   localparam logic [STAT_WIDTH-1:0] STAT_FULL  = 2'd1;
   localparam logic [STAT_WIDTH-1:0] STAT_BADID = 2'd2;
   localparam logic [STAT_WIDTH-1:0] STAT_EMPTY = 2'd3;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOOKUP,
      S_SCAN,
      S_RESOLVE,
      S_EMIT
   } state_type;

endpackage

`default_nettype wire

>>> sv/ppt_ram.sv
// Entry memory of the priority table: one write port, one read port.
// Read data is registered. No dependencies.
`default_nettype none

module ppt_ram #(
   parameter int WIDTH = 49,
   parameter int DEPTH = 64,
   localparam int ADDR_WIDTH = $clog2(DEPTH)
) (
   input  wire logic                  clock,
   input  wire logic                  wr_en,
   input  wire logic [ADDR_WIDTH-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]      wr_data,
   input  wire logic                  rd_en,
   input  wire logic [ADDR_WIDTH-1:0] rd_addr,
   output logic      [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> sv/promotable_priority_table.sv
// Promotable priority table top level; depends on ppt_pkg and ppt_ram.
// Add goes straight to S_EMIT; promote, get, is_valid read the entry in S_LOOKUP;
// get_max and pop_max walk all issued ids in S_SCAN, one entry per cycle through the
// single read port of the entry memory, then S_RESOLVE. One request is in work at a
// time; a new request is accepted only after S_EMIT loads the output register.
// Reset clears the fill count, state and response valid flag; no clearing pass.
`default_nettype none

module promotable_priority_table
   import ppt_pkg::*;
#(
   parameter int DEPTH      = 64,
   parameter int DATA_WIDTH = 32,
   parameter int PRIO_WIDTH = 16,
   localparam int ID_WIDTH    = $clog2(DEPTH),
   localparam int REQ_W       = ID_WIDTH + DATA_WIDTH,
   localparam int REQ_TDATA_W = ((REQ_W + 7) / 8) * 8,
   localparam int RSP_W       = ID_WIDTH + DATA_WIDTH + PRIO_WIDTH + 1,
   localparam int RSP_TDATA_W = ((RSP_W + 7) / 8) * 8
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,  // entry_id, data_in, zero pad
   input  wire logic [FUNC_WIDTH-1:0]  req_tuser,  // func
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic      [RSP_TDATA_W-1:0] rsp_tdata,  // id_out, data_out, prio_out,
                                                   // is_live, zero pad
   output logic      [STAT_WIDTH-1:0]  rsp_tuser   // status
);

   localparam int MEM_W = 1 + PRIO_WIDTH + DATA_WIDTH;
   localparam logic [ID_WIDTH:0] DEPTH_CNT = (ID_WIDTH + 1)'(DEPTH);

   state_type state_ff, state_in;
   logic [FUNC_WIDTH-1:0] func_ff, func_in;
   logic [ID_WIDTH-1:0]   id_ff, id_in;
   logic [ID_WIDTH:0]     next_id_ff, next_id_in;
   logic [ID_WIDTH-1:0]   rd_addr_ff, rd_addr_in;
   logic                  found_ff, found_in;
   logic [STAT_WIDTH-1:0] res_status_ff, res_status_in;
   logic [ID_WIDTH-1:0]   res_id_ff, res_id_in;
   logic [DATA_WIDTH-1:0] res_data_ff, res_data_in;
   logic [PRIO_WIDTH-1:0] res_prio_ff, res_prio_in;
   logic                  res_live_ff, res_live_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STAT_WIDTH-1:0] rsp_status_ff, rsp_status_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                  wr_en, rd_en;
   logic [ID_WIDTH-1:0]   wr_addr, rd_addr;
   logic [MEM_W-1:0]      wr_data, rd_data;

   logic [ID_WIDTH-1:0]   req_id;
   logic [DATA_WIDTH-1:0] req_din;
   logic                  req_fire;
   logic                  rd_live;
   logic [PRIO_WIDTH-1:0] rd_prio, prio_inc;
   logic [DATA_WIDTH-1:0] rd_dat;
   logic [ID_WIDTH:0]     scan_next;

   assign req_id   = req_tdata[ID_WIDTH-1:0];
   assign req_din  = req_tdata[ID_WIDTH +: DATA_WIDTH];
   assign req_fire = req_tvalid && req_tready;

   assign rd_live   = rd_data[MEM_W-1];
   assign rd_prio   = rd_data[DATA_WIDTH +: PRIO_WIDTH];
   assign rd_dat    = rd_data[DATA_WIDTH-1:0];
   assign prio_inc  = (rd_prio == '1) ? rd_prio : rd_prio + 1'b1;
   assign scan_next = {1'b0, rd_addr_ff} + 1'b1;

   ppt_ram #(
      .WIDTH (MEM_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         next_id_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         next_id_ff   <= next_id_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      id_ff         <= id_in;
      rd_addr_ff    <= rd_addr_in;
      found_ff      <= found_in;
      res_status_ff <= res_status_in;
      res_id_ff     <= res_id_in;
      res_data_ff   <= res_data_in;
      res_prio_ff   <= res_prio_in;
      res_live_ff   <= res_live_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
   end

   always_comb begin
      state_in      = state_ff;
      func_in       = func_ff;
      id_in         = id_ff;
      next_id_in    = next_id_ff;
      rd_addr_in    = rd_addr_ff;
      found_in      = found_ff;
      res_status_in = res_status_ff;
      res_id_in     = res_id_ff;
      res_data_in   = res_data_ff;
      res_prio_in   = res_prio_ff;
      res_live_in   = res_live_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      req_tready    = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = '0;
      rd_en         = 1'b0;
      rd_addr       = '0;

      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               func_in       = req_tuser;
               id_in         = req_id;
               found_in      = 1'b0;
               res_status_in = STAT_OK;
               res_id_in     = '0;
               res_data_in   = '0;
               res_prio_in   = '0;
               res_live_in   = 1'b0;
               state_in      = S_EMIT;
               case (req_tuser)
                  FN_ADD: begin
                     if (next_id_ff == DEPTH_CNT) begin
                        res_status_in = STAT_FULL;
                     end else begin
                        wr_en      = 1'b1;
                        wr_addr    = next_id_ff[ID_WIDTH-1:0];
                        wr_data    = {1'b1, {PRIO_WIDTH{1'b0}}, req_din};
                        res_id_in  = next_id_ff[ID_WIDTH-1:0];
                        next_id_in = next_id_ff + 1'b1;
                     end
                  end
                  FN_PROMOTE, FN_GET, FN_IS_VALID: begin
                     if ({1'b0, req_id} < next_id_ff) begin
                        rd_en    = 1'b1;
                        rd_addr  = req_id;
                        state_in = S_LOOKUP;
                     end else if (req_tuser != FN_IS_VALID) begin
                        res_status_in = STAT_BADID;
                     end
                  end
                  FN_GET_MAX, FN_POP_MAX: begin
                     if (next_id_ff == '0) begin
                        res_status_in = STAT_EMPTY;
                     end else begin
                        rd_en      = 1'b1;
                        rd_addr    = '0;
                        rd_addr_in = '0;
                        state_in   = S_SCAN;
                     end
                  end
                  default: begin
                     res_status_in = STAT_BADID;
                  end
               endcase
            end
         end
         S_LOOKUP: begin
            state_in = S_EMIT;
            if (!rd_live) begin
               if (func_ff != FN_IS_VALID) begin
                  res_status_in = STAT_BADID;
               end
            end else begin
               case (func_ff)
                  FN_IS_VALID: begin
                     res_live_in = 1'b1;
                  end
                  FN_GET: begin
                     res_id_in   = id_ff;
                     res_data_in = rd_dat;
                     res_prio_in = rd_prio;
                  end
                  FN_PROMOTE: begin
                     wr_en       = 1'b1;
                     wr_addr     = id_ff;
                     wr_data     = {1'b1, prio_inc, rd_dat};
                     res_id_in   = id_ff;
                     res_data_in = rd_dat;
                     res_prio_in = prio_inc;
                  end
                  default: begin
                     res_status_in = STAT_BADID;
                  end
               endcase
            end
         end
         S_SCAN: begin
            // ties go to the later (larger) id
            if (rd_live && (!found_ff || rd_prio >= res_prio_ff)) begin
               found_in    = 1'b1;
               res_id_in   = rd_addr_ff;
               res_data_in = rd_dat;
               res_prio_in = rd_prio;
            end
            if (scan_next < next_id_ff) begin
               rd_en      = 1'b1;
               rd_addr    = scan_next[ID_WIDTH-1:0];
               rd_addr_in = scan_next[ID_WIDTH-1:0];
            end else begin
               state_in = S_RESOLVE;
            end
         end
         S_RESOLVE: begin
            state_in = S_EMIT;
            if (!found_ff) begin
               res_status_in = STAT_EMPTY;
            end else if (func_ff == FN_POP_MAX) begin
               wr_en   = 1'b1;
               wr_addr = res_id_ff;
               wr_data = {1'b0, res_prio_ff, res_data_ff};
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_data_in   = RSP_TDATA_W'({res_live_ff, res_prio_ff, res_data_ff,
                                             res_id_ff});
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      next_id_ff <= DEPTH_CNT)
      else $error("fill count beyond depth");

   a_add_counts: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tuser == FN_ADD && next_id_ff != DEPTH_CNT)
      |=> next_id_ff == $past(next_id_ff) + 1'b1)
      else $error("add did not advance fill count");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != STAT_OK) |-> rsp_tdata == '0)
      else $error("error response carries data");

   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_tready)
      else $error("second request taken while one in work");

   a_pop_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESOLVE && func_ff == FN_POP_MAX && found_ff)
      |-> (wr_en && !wr_data[MEM_W-1] && wr_addr == res_id_ff))
      else $error("pop did not invalidate entry");

endmodule

`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for promotable_priority_table: a shadow table predicts each
// response and a checker compares it field by field. Depends on ppt_pkg and the RTL.
`timescale 1ns / 1ps

module tb
   import ppt_pkg::*;
();

   typedef struct packed {
      logic [STAT_WIDTH-1:0] status;
      logic [5:0]            id_out;
      logic [31:0]           data_out;
      logic [15:0]           prio_out;
      logic                  is_live;
   } table_rsp_type;

   class ppt_shadow;
      localparam int N_ENTRIES = 64;

      bit            live[N_ENTRIES];
      logic [15:0]   prio_of[N_ENTRIES];
      logic [31:0]   data_of[N_ENTRIES];
      int            next_id;
      table_rsp_type expected_rsp[$];
      int            requests;
      int            responses;
      int            errors;
      int            status_seen[4];
      int            saturated_promotes;

      function new();
         next_id = 0;
         foreach (live[i]) live[i] = 1'b0;
      endfunction

      function bit entry_live(logic [5:0] id);
         return (int'(id) < next_id) && live[id];
      endfunction

      function int max_entry();
         int best;
         best = -1;
         for (int i = 0; i < N_ENTRIES; i++)
            if (live[i] && (best < 0 || prio_of[i] >= prio_of[best])) best = i;
         return best;
      endfunction

      function void note_request(logic [FUNC_WIDTH-1:0] fn, logic [5:0] id,
                                 logic [31:0] din);
         table_rsp_type r;
         int            best;
         r = '0;
         r.status = STAT_OK;
         case (fn)
            FN_ADD: begin
               if (next_id >= N_ENTRIES) begin
                  r.status = STAT_FULL;
               end else begin
                  live[next_id] = 1'b1;
                  prio_of[next_id] = '0;
                  data_of[next_id] = din;
                  r.id_out = 6'(next_id);
                  next_id++;
               end
            end
            FN_PROMOTE: begin
               if (!entry_live(id)) begin
                  r.status = STAT_BADID;
               end else begin
                  if (prio_of[id] != '1) prio_of[id]++;
                  else saturated_promotes++;
                  r.id_out = id;
                  r.data_out = data_of[id];
                  r.prio_out = prio_of[id];
               end
            end
            FN_GET_MAX, FN_POP_MAX: begin
               best = max_entry();
               if (best < 0) begin
                  r.status = STAT_EMPTY;
               end else begin
                  r.id_out = 6'(best);
                  r.data_out = data_of[best];
                  r.prio_out = prio_of[best];
                  if (fn == FN_POP_MAX) live[best] = 1'b0;
               end
            end
            FN_IS_VALID: begin
               r.is_live = entry_live(id);
            end
            FN_GET: begin
               if (!entry_live(id)) begin
                  r.status = STAT_BADID;
               end else begin
                  r.id_out = id;
                  r.data_out = data_of[id];
                  r.prio_out = prio_of[id];
               end
            end
            default: begin
               r.status = STAT_BADID;
            end
         endcase
         expected_rsp = {expected_rsp, r};
         requests++;
      endfunction

      function void compare(string field, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
            errors++;
         end
      endfunction

      function void check_response(logic [STAT_WIDTH-1:0] st, logic [55:0] td);
         table_rsp_type want;
         if (expected_rsp.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual status %h tdata %h",
                     $time, st, td);
            errors++;
            return;
         end
         want = expected_rsp.pop_front();
         responses++;
         status_seen[want.status]++;
         compare("status", 32'(want.status), 32'(st));
         compare("id_out", 32'(want.id_out), 32'(td[5:0]));
         compare("data_out", want.data_out, td[37:6]);
         compare("prio_out", 32'(want.prio_out), 32'(td[53:38]));
         compare("is_live", 32'(want.is_live), 32'(td[54]));
      endfunction
   endclass

   localparam int N_ENTRIES      = 64;
   localparam int REQ_TDATA_W    = 40;
   localparam int RSP_TDATA_W    = 56;
   localparam int N_RANDOM       = 1260;
   localparam int HOLD_CYCLES    = 400;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES  = 80;
   localparam logic [FUNC_WIDTH-1:0] FN_UNUSED_LO = 3'd6;
   localparam logic [FUNC_WIDTH-1:0] FN_UNUSED_HI = 3'd7;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;   // entry_id, data_in, zero pad
   logic [FUNC_WIDTH-1:0]  req_tuser;   // func
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;   // id_out, data_out, prio_out, is_live, zero pad
   logic [STAT_WIDTH-1:0]  rsp_tuser;   // status

   bit tx_idle_on;
   bit rx_idle_on;
   bit hold_go;
   bit hold_done;
   int quiet_cycles;

   ppt_shadow shadow = new();

   promotable_priority_table uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_go && !hold_done) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end
         rsp_tready <= rx_idle_on ? ($urandom_range(99) >= 21) : 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) shadow.check_response(rsp_tuser, rsp_tdata);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog, no handshake for %0d cycles", $time, quiet_cycles);
         $display("tb: done, errors");
         $finish;
      end
   end

   task automatic send(input logic [FUNC_WIDTH-1:0] fn, input logic [5:0] id,
                       input logic [31:0] din);
      req_tvalid <= 1'b1;
      req_tuser  <= fn;
      req_tdata  <= {2'b00, din, id};
      do @(posedge clock); while (!req_tready);
      shadow.note_request(fn, id, din);
      if (tx_idle_on && $urandom_range(99) < 21) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (shadow.expected_rsp.size() != 0) @(posedge clock);
   endtask

   // mostly issued ids; add and pop kept rare
   task automatic random_request();
      int          pick;
      logic [5:0]  id;
      logic [31:0] din;
      pick = $urandom_range(99);
      din  = $urandom;
      id   = 6'($urandom_range(63));
      if (shadow.next_id > 0 && $urandom_range(99) < 85)
         id = 6'($urandom_range(shadow.next_id - 1));
      if (pick < 6)       send(FN_ADD, id, din);
      else if (pick < 10) send(FN_POP_MAX, id, din);
      else if (pick < 20) send(FN_GET_MAX, id, din);
      else if (pick < 58) send(FN_PROMOTE, id, din);
      else if (pick < 73) send(FN_IS_VALID, id, din);
      else if (pick < 96) send(FN_GET, id, din);
      else if (pick < 98) send(FN_UNUSED_LO, id, din);
      else                send(FN_UNUSED_HI, id, din);
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;

      // empty table, unissued ids, unused codes
      send(FN_GET_MAX, 6'h00, 32'h0);
      send(FN_POP_MAX, 6'h3F, 32'h0);
      send(FN_IS_VALID, 6'h00, 32'h0);
      send(FN_GET, 6'h3F, 32'hFFFF_FFFF);
      send(FN_PROMOTE, 6'h00, 32'h0);
      send(FN_UNUSED_LO, 6'h2A, 32'h1234_5678);
      send(FN_UNUSED_HI, 6'h15, 32'h8765_4321);
      // adds, the id field is ignored
      send(FN_ADD, 6'h3F, 32'h0000_0000);
      send(FN_ADD, 6'h00, 32'hFFFF_FFFF);
      send(FN_ADD, 6'h15, 32'hA5A5_5A5A);
      send(FN_GET, 6'h00, 32'h0);
      send(FN_GET, 6'h01, 32'h0);
      send(FN_IS_VALID, 6'h02, 32'h0);
      send(FN_IS_VALID, 6'h03, 32'h0);
      send(FN_GET, 6'h03, 32'h0);
      // tie on priority goes to the larger id
      send(FN_PROMOTE, 6'h01, 32'h0);
      send(FN_PROMOTE, 6'h02, 32'h0);
      send(FN_GET_MAX, 6'h00, 32'h0);
      send(FN_POP_MAX, 6'h00, 32'h0);
      send(FN_GET, 6'h02, 32'h0);
      send(FN_PROMOTE, 6'h02, 32'h0);
      send(FN_IS_VALID, 6'h02, 32'h0);
      send(FN_GET_MAX, 6'h00, 32'h0);

      for (int n = 0; n < N_RANDOM; n++) begin
         if (n == 250) hold_go <= 1'b1;
         tx_idle_on = !(n >= 450 && n < 650);
         rx_idle_on = tx_idle_on;
         if (n == 800) wait_drained();
         random_request();
      end

      // fill to the last id, one refused add, then pop until empty
      while (shadow.next_id < N_ENTRIES) send(FN_ADD, 6'($urandom), $urandom);
      send(FN_ADD, 6'($urandom), $urandom);
      repeat (N_ENTRIES) send(FN_POP_MAX, 6'($urandom), $urandom);
      send(FN_GET_MAX, 6'($urandom), $urandom);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (shadow.expected_rsp.size() != 0) begin
         $display("%0t: %0d responses expected but never received", $time,
                  shadow.expected_rsp.size());
         shadow.errors += shadow.expected_rsp.size();
      end
      $display("tb: %0d requests, %0d responses checked, %0d saturated promotes",
               shadow.requests, shadow.responses, shadow.saturated_promotes);
      $display("tb: status ok %0d, full %0d, bad id %0d, empty %0d; %0d mismatches",
               shadow.status_seen[STAT_OK], shadow.status_seen[STAT_FULL],
               shadow.status_seen[STAT_BADID], shadow.status_seen[STAT_EMPTY],
               shadow.errors);
      if (shadow.errors == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end
endmodule
